// File: sv/lpfr_pkg.sv
`default_nettype none
package lpfr_pkg;

  localparam int unsigned MAX_LEN_RESET = 250 * 1024;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CFG_IDX_W     = 1;

  localparam logic [1:0] POS_LAST = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BIG_END = CFG_IDX_W'(1);

  // frame parser phase; code 3 is unused and behaves as PH_HEADER
  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_PAYLOAD  = 2'd1,
    PH_CHECKSUM = 2'd2
  } phase_t;

  // work handed from front to back
  typedef enum logic [1:0] {
    OP_PAYLOAD = 2'd0,
    OP_CHECK   = 2'd1,
    OP_TOOBIG  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data_byte;   // payload byte
    logic [1:0]  pos;         // byte position in payload word
    logic        big_endian;  // word order for this payload byte
    logic [31:0] checksum;    // received checksum (OP_CHECK)
    logic [31:0] length;      // header length (status ops)
  } entry_t;

endpackage
`default_nettype wire

// File: sv/length_prefixed_frame_receiver.sv
// A result is written into the queue at the edge that accepts its byte, then moves
//   into the output register in the back once that register is free to load.
// Throughput: 1 byte per cycle; the 2-entry queue between parser and checksum
//   unit raises in_stall only when out_stall has held it full.
// Reset (rst_n low at a clock edge): parser waits for a header, running sum 0,
//   queue and output empty, max_payload_length 256000, little-endian words.
`default_nettype none
module length_prefixed_frame_receiver import lpfr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // received byte stream
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_rx_byte,
  // results
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_result_kind,
  output logic [7:0]                out_payload_byte,
  output logic [31:0]               out_frame_length,
  // register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  // configuration registers
  logic [31:0] max_len_r;
  logic        big_end_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= 32'(MAX_LEN_RESET);
      big_end_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_MAX_LEN: max_len_r <= cfg_data;
        CFG_IDX_BIG_END: big_end_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: parses headers/checksums, queues each payload byte and each frame status for the back
  logic   in_accept;
  logic   q_push;
  entry_t q_push_entry;

  assign in_accept = in_valid && !in_stall;

  lpfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .rx_byte    (in_rx_byte),
    .max_len    (max_len_r),
    .big_endian (big_end_r),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  // queue decouples the parser from output backpressure
  entry_t              q_head;
  logic                q_not_empty;
  logic                q_full;
  logic                q_pop;
  logic [QCNT_W-1:0]   q_count;

  // stall on full; a byte that pushes nothing is also held, which is harmless
  assign in_stall = q_full;

  lpfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .not_empty  (q_not_empty),
    .full       (q_full),
    .count      (q_count)
  );

  // back: word sum, checksum compare, output register
  lpfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .not_empty  (q_not_empty),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_result_kind),
    .out_byte   (out_payload_byte),
    .out_length (out_frame_length)
  );

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_count != '0)
    else $error("pop from empty queue");

  a_payload_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_PAYLOAD |-> out_frame_length == 32'd0)
    else $error("payload result carries a length");

  a_status_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != KIND_PAYLOAD |-> out_payload_byte == 8'd0)
    else $error("status result carries a byte");
`endif

endmodule
`default_nettype wire

// File: sv/lpfr_front.sv
`default_nettype none
module lpfr_front import lpfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [31:0] max_len,
  input  wire logic        big_endian,
  output logic             push,
  output entry_t           push_entry
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] hdr_r, hdr_nxt;
  logic [31:0] cks_r, cks_nxt;
  logic [31:0] plen_r, plen_nxt;
  logic [31:0] brx_r, brx_nxt;

  logic [31:0] hdr_shift;
  logic [31:0] cks_shift;
  logic [31:0] brx_inc;
  logic        too_big;

  assign hdr_shift = {hdr_r[23:0], rx_byte};
  assign cks_shift = {cks_r[23:0], rx_byte};
  assign brx_inc   = brx_r + 32'd1;
  assign too_big   = hdr_shift > max_len;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      case (phase_r)
        PH_PAYLOAD: begin
          if (brx_inc == plen_r) phase_nxt = PH_CHECKSUM;
        end
        PH_CHECKSUM: begin
          if (cnt_r == POS_LAST) phase_nxt = PH_HEADER;
        end
        default: begin
          phase_nxt = PH_HEADER;
          if (cnt_r == POS_LAST && !too_big) begin
            phase_nxt = (hdr_shift == 32'd0) ? PH_CHECKSUM : PH_PAYLOAD;
          end
        end
      endcase
    end
  end

  // datapath and queue push
  always_comb begin
    cnt_nxt    = cnt_r;
    hdr_nxt    = hdr_r;
    cks_nxt    = cks_r;
    plen_nxt   = plen_r;
    brx_nxt    = brx_r;
    push       = 1'b0;
    push_entry = '{op: OP_PAYLOAD, data_byte: rx_byte, pos: cnt_r,
                   big_endian: big_endian, checksum: cks_shift, length: plen_r};
    if (accept) begin
      case (phase_r)
        PH_PAYLOAD: begin
          push    = 1'b1;
          brx_nxt = brx_inc;
          cnt_nxt = (cnt_r == POS_LAST) ? 2'd0 : cnt_r + 2'd1;
          if (brx_inc == plen_r) cnt_nxt = 2'd0;
        end
        PH_CHECKSUM: begin
          cks_nxt = cks_shift;
          if (cnt_r == POS_LAST) begin
            push          = 1'b1;
            push_entry.op = OP_CHECK;
            cnt_nxt       = 2'd0;
            cks_nxt       = 32'd0;
          end else begin
            cnt_nxt = cnt_r + 2'd1;
          end
        end
        default: begin
          hdr_nxt = hdr_shift;
          if (cnt_r == POS_LAST) begin
            cnt_nxt = 2'd0;
            hdr_nxt = 32'd0;
            if (too_big) begin
              push              = 1'b1;
              push_entry.op     = OP_TOOBIG;
              push_entry.length = hdr_shift;
            end else begin
              plen_nxt = hdr_shift;
              brx_nxt  = 32'd0;
              cks_nxt  = 32'd0;
            end
          end else begin
            cnt_nxt = cnt_r + 2'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      cnt_r   <= 2'd0;
      hdr_r   <= 32'd0;
      cks_r   <= 32'd0;
      plen_r  <= 32'd0;
      brx_r   <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      hdr_r   <= hdr_nxt;
      cks_r   <= cks_nxt;
      plen_r  <= plen_nxt;
      brx_r   <= brx_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/lpfr_queue.sv
`default_nettype none
module lpfr_queue import lpfr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire entry_t            push_entry,
  input  wire logic              pop,
  output entry_t                 head,
  output logic                   not_empty,
  output logic                   full,
  output logic [QCNT_W-1:0]      count
);

  entry_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wp_r, wp_nxt;
  logic [QPTR_W-1:0]   rp_r, rp_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign head      = mem_r[rp_r];
  assign not_empty = cnt_r != '0;
  assign full      = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign count     = cnt_r;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + QPTR_W'(1);
    if (pop)  rp_nxt = (rp_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + QPTR_W'(1);
    if (push && !pop)      cnt_nxt = cnt_r + QCNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/lpfr_back.sv
`default_nettype none
module lpfr_back import lpfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire entry_t      head,
  input  wire logic        not_empty,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic [31:0]      out_length
);

  logic        ovalid_r;
  kind_t       okind_r, okind_nxt;
  logic [7:0]  obyte_r, obyte_nxt;
  logic [31:0] olen_r, olen_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [7:0]  wb0_r, wb1_r, wb2_r;
  logic [31:0] word;
  logic        load;

  assign load = !ovalid_r || !out_stall;
  assign pop  = not_empty && load;

  assign word = head.big_endian ? {wb0_r, wb1_r, wb2_r, head.data_byte}
                                : {head.data_byte, wb2_r, wb1_r, wb0_r};

  always_comb begin
    okind_nxt = KIND_PAYLOAD;
    obyte_nxt = 8'd0;
    olen_nxt  = head.length;
    sum_nxt   = sum_r;
    case (head.op)
      OP_PAYLOAD: begin
        obyte_nxt = head.data_byte;
        olen_nxt  = 32'd0;
        if (head.pos == POS_LAST) sum_nxt = sum_r + word;
      end
      OP_CHECK: begin
        okind_nxt = (head.checksum == sum_r) ? KIND_GOOD : KIND_MISMATCH;
        sum_nxt   = 32'd0;
      end
      default: begin
        okind_nxt = KIND_TOO_LONG;
      end
    endcase
  end

  // partial word bytes; each word starts at position 0 so no clear needed
  always_ff @(posedge clk) begin
    if (pop && head.op == OP_PAYLOAD) begin
      case (head.pos)
        2'd0:    wb0_r <= head.data_byte;
        2'd1:    wb1_r <= head.data_byte;
        2'd2:    wb2_r <= head.data_byte;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      okind_r <= okind_nxt;
      obyte_r <= obyte_nxt;
      olen_r  <= olen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      sum_r    <= 32'd0;
    end else begin
      if (load) ovalid_r <= not_empty;
      if (pop)  sum_r    <= sum_nxt;
    end
  end

  assign out_valid  = ovalid_r;
  assign out_kind   = okind_r;
  assign out_byte   = obyte_r;
  assign out_length = olen_r;

endmodule
`default_nettype wire

// File: tb/length_prefixed_frame_receiver_test.sv
`default_nettype none
module length_prefixed_frame_receiver_test;
  import lpfr_pkg::*;

  // extra wait after the last predicted result, as margin
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT      = 5000;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned MAX_REPORTS      = 10;

  // one expected output item
  typedef struct {
    kind_t       kind;
    logic [7:0]  data;
    logic [31:0] length;
  } frame_event_t;

  // Frame parser mirror plus the queue of output items it predicts.
  class frame_rx_scoreboard;
    phase_t       phase;
    logic [1:0]   pos;
    logic [31:0]  header_bits;
    logic [31:0]  frame_len;
    logic [31:0]  payload_seen;
    logic [31:0]  word_sum;
    logic [23:0]  partial_word;
    logic [31:0]  checksum_bits;
    logic [31:0]  max_len;
    logic         big_endian;
    frame_event_t events_due[$];
    int unsigned  mismatches;

    function new();
      max_len    = MAX_LEN_RESET;
      big_endian = 1'b0;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      phase         = PH_HEADER;
      pos           = '0;
      header_bits   = '0;
      frame_len     = '0;
      payload_seen  = '0;
      word_sum      = '0;
      partial_word  = '0;
      checksum_bits = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_IDX_MAX_LEN: max_len = data;
        CFG_IDX_BIG_END: big_endian = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return events_due.size();
    endfunction

    // append one predicted item at the tail
    function void add_event(frame_event_t ev);
      events_due.insert(events_due.size(), ev);
    endfunction

    // advance the parser by one accepted byte
    function void parse_rx_byte(logic [7:0] b);
      logic [31:0]  word;
      frame_event_t ev;
      case (phase)
        PH_PAYLOAD: begin
          if (pos == POS_LAST) begin
            if (big_endian)
              word = {partial_word[7:0], partial_word[15:8], partial_word[23:16], b};
            else
              word = {b, partial_word};
            word_sum     = word_sum + word;
            partial_word = '0;
            pos          = '0;
          end else begin
            partial_word[8*pos +: 8] = b;
            pos++;
          end
          payload_seen++;
          if (payload_seen == frame_len) begin
            phase         = PH_CHECKSUM;
            pos           = '0;
            partial_word  = '0;
            checksum_bits = '0;
          end
          ev.kind   = KIND_PAYLOAD;
          ev.data   = b;
          ev.length = 32'h0;
          add_event(ev);
        end
        PH_CHECKSUM: begin
          checksum_bits = {checksum_bits[23:0], b};
          if (pos == POS_LAST) begin
            if (checksum_bits == word_sum) ev.kind = KIND_GOOD;
            else ev.kind = KIND_MISMATCH;
            ev.data   = 8'h00;
            ev.length = frame_len;
            clear_frame();
            add_event(ev);
          end else begin
            pos++;
          end
        end
        default: begin
          phase       = PH_HEADER;
          header_bits = {header_bits[23:0], b};
          if (pos != POS_LAST) begin
            pos++;
          end else if (header_bits > max_len) begin
            ev.kind   = KIND_TOO_LONG;
            ev.data   = 8'h00;
            ev.length = header_bits;
            add_event(ev);
            clear_frame();
          end else begin
            frame_len     = header_bits;
            header_bits   = '0;
            pos           = '0;
            payload_seen  = '0;
            word_sum      = '0;
            partial_word  = '0;
            checksum_bits = '0;
            if (frame_len == 0) phase = PH_CHECKSUM;
            else phase = PH_PAYLOAD;
          end
        end
      endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic [31:0] length);
      frame_event_t want;
      if (events_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected output: kind %0d byte %02h len %08h", kind, data, length);
        return;
      end
      want = events_due.pop_front();
      if (want.kind !== kind || want.data !== data || want.length !== length) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: want kind %0d byte %02h len %08h, got kind %0d byte %02h len %08h",
                   want.kind, want.data, want.length, kind, data, length);
      end
    endfunction
  endclass

  // clock, reset and block inputs, all known from time zero
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic [7:0]           in_rx_byte = 8'h00;
  logic                 out_stall  = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [31:0]          cfg_data   = '0;

  logic                 in_stall;
  logic                 out_valid;
  logic [1:0]           out_result_kind;
  logic [7:0]           out_payload_byte;
  logic [31:0]          out_frame_length;
  logic                 cfg_ready;

  // stimulus knobs
  int unsigned sender_idle_pct = 0;
  int unsigned rx_stall_pct    = 0;
  int unsigned hold_requests   = 0;
  int unsigned holds_served    = 0;
  int unsigned hold_left       = 0;
  int unsigned bytes_sent      = 0;

  // mirror of what the registers hold, used to build frames
  logic [31:0] cur_max = MAX_LEN_RESET;
  logic        cur_be  = 1'b0;

  frame_rx_scoreboard sb;

  // directed bytes: oversize header of all ones, an empty frame with a good
  // checksum, then a five-byte frame with extreme bytes, a trailing byte
  // past the word and a wrong checksum
  logic [7:0] directed_bytes [25] = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h00, 8'h00, 8'h00, 8'h00,  8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h05,  8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F,
    8'hFF, 8'hFF, 8'hFF, 8'hFF
  };

  always #10 clk = ~clk;

  length_prefixed_frame_receiver i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_payload_byte (out_payload_byte),
    .out_frame_length (out_frame_length),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Receiver side. A new hold request starts a long stall that outlasts the
  // block's buffering; otherwise stall at the current random rate.
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= LONG_HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // output monitor: values read here are the ones the edge acts on
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_result_kind, out_payload_byte, out_frame_length);
  end

  // hang guard
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Offer one byte and hold it until taken, then maybe go idle for a while.
  // in_valid stays high when the next byte follows right away.
  task automatic send_byte(input logic [7:0] b);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.parse_rx_byte(b);
    bytes_sent++;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // only called with the block drained
  task automatic apply_settings(input logic [31:0] max_len, input logic big_end);
    logic [31:0] be_word;
    be_word = $urandom;
    be_word[0] = big_end;
    cfg_write(CFG_IDX_MAX_LEN, max_len);
    cfg_write(CFG_IDX_BIG_END, be_word);
    cur_max = max_len;
    cur_be  = big_end;
  endtask

  task automatic set_idling(input int unsigned sender_pct, input int unsigned rx_pct);
    sender_idle_pct = sender_pct;
    rx_stall_pct   <= rx_pct;
  endtask

  // Stop offering, wait for every predicted item, then let header and
  // checksum bytes (which give nothing) clear the pipeline too.
  task automatic drain();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_length(input logic [31:0] len);
    for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
  endtask

  // Random payload followed by its checksum, optionally spoiled. The word
  // register shifts so that the first byte lands where cur_be puts it.
  task automatic send_body(input logic [31:0] len, input bit corrupt);
    logic [31:0] word;
    logic [31:0] sum;
    logic [31:0] csum;
    logic [7:0]  b;
    word = '0;
    sum  = '0;
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom);
      send_byte(b);
      word = cur_be ? {word[23:0], b} : {b, word[31:8]};
      if (i[1:0] == 2'd3) sum = sum + word;
    end
    csum = sum;
    if (corrupt) begin
      if ($urandom_range(1)) csum = sum ^ (32'h1 << $urandom_range(31));
      else csum = $urandom;
    end
    send_length(csum);
  endtask

  // Mostly well-formed frames with random contents; some oversize headers
  // and bad checksums mixed in. Lengths stay short so frames turn over fast.
  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned start;
    int unsigned pick;
    logic [31:0] len;
    logic [31:0] lim;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 12 && cur_max != 32'hFFFF_FFFF) begin
        len = $urandom;
        if (len <= cur_max) len = cur_max + 1;
        send_length(len);
      end else begin
        lim = (pick < 22) ? 32'd64 : 32'd24;
        if (lim > cur_max) lim = cur_max;
        if (pick >= 22 && pick < 30) len = lim;
        else len = $urandom_range(lim, 0);
        send_length(len);
        send_body(len, $urandom_range(99) < 20);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset-like settings
    set_idling(0, 0);
    apply_settings(MAX_LEN_RESET, 1'b0);
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    drain();

    // no length limit, little-endian words, no idling
    apply_settings(32'hFFFF_FFFF, 1'b0);
    random_traffic(150);

    // Half a header goes in before the limit changes: the limit counts only
    // at the last header byte. The frame sits exactly at the new limit.
    send_byte(8'h00);
    send_byte(8'h00);
    drain();
    apply_settings(32'd16, 1'b1);
    set_idling(76, 0);
    send_byte(8'h00);
    send_byte(8'h10);
    send_body(32'd16, 1'b0);
    random_traffic(150);
    drain();

    // zero limit: only empty frames pass, everything else is oversize
    apply_settings(32'd0, 1'b1);
    set_idling(0, 76);
    random_traffic(150);
    drain();

    apply_settings(MAX_LEN_RESET, 1'b0);
    set_idling(30, 30);
    random_traffic(150);
    drain();

    // Back-pressure: the receiver holds off long enough for the queue to
    // fill and in_stall to rise while bytes keep coming. Then the sender
    // waits for everything to come out before resuming.
    apply_settings(32'($urandom_range(40, 8)), 1'($urandom_range(1)));
    set_idling(0, 0);
    hold_requests <= hold_requests + 1;
    random_traffic(70);
    drain();
    set_idling(30, 30);
    random_traffic(50);
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
